// ===== hw/rtl/soh_pkg.sv =====
package soh_pkg;

  localparam int HOLD_N = 16;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;
  localparam int CFG_AW = 3;

  localparam logic [15:0] MIN_LEN = 16'd26;
  localparam logic [15:0] HOLD_FIRST = 16'd10;
  localparam logic [15:0] HOLD_LAST = 16'd23;
  localparam logic [15:0] ADJ_OFF = 16'd11;
  localparam logic [15:0] ADDR_OFF = 16'd24;
  localparam logic [15:0] ADDR_OFF2 = 16'd25;
  localparam logic [15:0] WORD_ADJ = 16'd4;
  localparam logic [15:0] TAIL_TRIM = 16'd5;

  localparam logic [3:0] ADDR_LO_IDX = 4'd14;
  localparam logic [3:0] ADDR_HI_IDX = 4'd15;
  localparam logic [3:0] FULL_CNT = 4'd15;
  localparam logic [3:0] CNT_BIAS = 4'd10;

  localparam logic CFG_REG_BEW = 1'b0;

  typedef logic [HOLD_N-1:0][7:0] hdr_t;

  typedef struct packed {
    logic       is_flush;
    logic [7:0] data;
    logic       end_flag;
    logic [3:0] cnt;
  } q_entry_t;

  function automatic logic [15:0] join_word(input logic be, input logic [7:0] first,
                                            input logic [7:0] second);
    return be ? {first, second} : {second, first};
  endfunction

  function automatic logic is_health(input logic [15:0] addr);
    logic hit;
    unique case (addr)
      16'd4416, 16'd4384, 16'd4368, 16'd9217, 16'd9218, 16'd9985,
      16'd9729, 16'd4609, 16'd8705, 16'd1281, 16'd1282, 16'd8544,
      16'd8464, 16'd272,  16'd320,  16'd4544, 16'd8640: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== hw/rtl/soh_fifo.sv =====
module soh_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  soh_pkg::q_entry_t  push_data,
  input  logic               pop,
  output soh_pkg::q_entry_t  head,
  output logic               full,
  output logic               empty
);
  import soh_pkg::*;

  q_entry_t        mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_AW:0]   cnt;

  assign full  = (cnt == (Q_AW+1)'(Q_DEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + Q_AW'(1);
      if (pop) rptr <= rptr + Q_AW'(1);
      if (push && !pop) cnt <= cnt + (Q_AW+1)'(1);
      else if (pop && !push) cnt <= cnt - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

endmodule

// ===== hw/rtl/soh_front.sv =====
module soh_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               bew,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               buffer_end,
  output logic               push_valid,
  output soh_pkg::q_entry_t  push_data,
  input  logic               q_full,
  input  logic               flush_done,
  output soh_pkg::hdr_t      held
);
  import soh_pkg::*;

  logic [15:0] offset, offset_next;
  logic [15:0] mlen, mlen_next;
  logic        passing, passing_next;
  logic        halted, halted_next;
  logic        busy, busy_next;

  logic        acc;
  logic        in_mid;
  logic        writes_held;
  logic [15:0] last;
  logic [15:0] len1;
  logic [15:0] addr;
  logic [15:0] adj;
  logic [15:0] hoff;
  logic [16:0] off_inc;

  assign acc         = in_valid && in_ready;
  assign in_mid      = !halted && (offset >= 16'd2) && (mlen >= MIN_LEN);
  assign writes_held = in_mid && (offset >= HOLD_FIRST) && (offset <= ADDR_OFF2);
  // hold off header writes while the back end still drains the last flush
  assign in_ready    = !q_full && !(busy && writes_held);

  assign last    = mlen - TAIL_TRIM;
  assign len1    = join_word(bew, mlen[7:0], in_byte);
  assign addr    = join_word(bew, held[ADDR_LO_IDX], in_byte);
  assign adj     = join_word(bew, held[0], in_byte) - WORD_ADJ;
  assign hoff    = offset - HOLD_FIRST;
  assign off_inc = {1'b0, offset} + 17'd1;

  always_comb begin
    offset_next  = offset;
    mlen_next    = mlen;
    passing_next = passing;
    halted_next  = halted;
    push_valid   = 1'b0;
    push_data    = '0;
    if (acc) begin
      if (!halted) begin
        if (offset == 16'd0) begin
          mlen_next   = {8'd0, in_byte};
          offset_next = 16'd1;
        end else if (offset == 16'd1) begin
          if (len1 == 16'd0 || len1[15]) begin
            halted_next = 1'b1;
            offset_next = 16'd0;
          end else if (len1 == 16'd1) begin
            mlen_next   = {8'd0, in_byte};
            offset_next = 16'd1;
          end else begin
            mlen_next   = len1;
            offset_next = (len1 == 16'd2) ? 16'd0 : 16'd2;
          end
        end else begin
          if (mlen >= MIN_LEN) begin
            if (offset == ADDR_OFF2) begin
              if (is_health(addr)) begin
                push_valid         = 1'b1;
                push_data.is_flush = 1'b1;
                push_data.end_flag = (last <= ADDR_OFF2);
                push_data.cnt      = (last >= ADDR_OFF2) ? FULL_CNT
                                                         : (last[3:0] - CNT_BIAS);
                passing_next       = (last > ADDR_OFF2);
              end
            end else if (offset > ADDR_OFF2 && passing) begin
              push_valid         = 1'b1;
              push_data.data     = in_byte;
              push_data.end_flag = (offset == last);
              if (offset == last) passing_next = 1'b0;
            end
          end
          offset_next = (off_inc >= {1'b0, mlen}) ? 16'd0 : off_inc[15:0];
        end
      end
      if (buffer_end) begin
        offset_next  = '0;
        mlen_next    = '0;
        passing_next = 1'b0;
        halted_next  = 1'b0;
      end
    end
  end

  always_comb begin
    busy_next = busy;
    if (push_valid && push_data.is_flush) busy_next = 1'b1;
    else if (flush_done) busy_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset  <= '0;
      mlen    <= '0;
      passing <= 1'b0;
      halted  <= 1'b0;
      busy    <= 1'b0;
    end else begin
      offset  <= offset_next;
      mlen    <= mlen_next;
      passing <= passing_next;
      halted  <= halted_next;
      busy    <= busy_next;
    end
  end

  // header store: offset 11 rewrites the first word lowered by four
  always_ff @(posedge clk) begin
    if (acc && in_mid) begin
      if (offset == ADJ_OFF) begin
        held[0] <= bew ? adj[15:8] : adj[7:0];
        held[1] <= bew ? adj[7:0] : adj[15:8];
      end else if (offset >= HOLD_FIRST && offset <= HOLD_LAST) begin
        held[hoff[3:0]] <= in_byte;
      end
      if (offset == ADDR_OFF) held[ADDR_LO_IDX] <= in_byte;
      if (offset == ADDR_OFF2) held[ADDR_HI_IDX] <= in_byte;
    end
  end

endmodule

// ===== hw/rtl/soh_back.sv =====
module soh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  soh_pkg::q_entry_t  q_head,
  output logic               q_pop,
  input  soh_pkg::hdr_t      held,
  output logic               flush_done,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               message_end,
  output logic               run_last
);
  import soh_pkg::*;

  logic [3:0] idx;
  logic       load;
  logic       fin;

  assign load       = !q_empty && (!out_valid || out_ready);
  assign fin        = q_head.is_flush ? (idx == q_head.cnt) : 1'b1;
  assign q_pop      = load && fin;
  assign flush_done = load && q_head.is_flush && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load) idx <= (q_head.is_flush && !fin) ? idx + 4'd1 : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= q_head.is_flush ? held[idx] : q_head.data;
      message_end <= q_head.end_flag && fin;
      run_last    <= fin;
    end
  end

endmodule

// ===== hw/rtl/soh_message_extractor.sv =====
// Health-message extractor for a byte stream of length-prefixed logger messages.
// Input channel (in_valid/in_ready): one buffer word per handshake, in_byte plus
// buffer_end on the last byte of a buffer. Output channel (out_valid/out_ready):
// one word per handshake, out_byte with message_end on the last byte of an
// extracted message and run_last on the last word caused by one input word.
// The APB port holds big_endian_words at byte address 0 (0 = little endian).
// With the queue empty, a pass-through byte goes into the queue at its accepting
// edge, then into the output register. The byte at offset 25 of a health message
// releases up to 16 held header store words, one per cycle while out_ready holds.
// Throughput: one input word per cycle and one output word per cycle; the
// four-entry queue between parser and output lets the parser run ahead while
// a header flush drains. The parser stalls when the queue is full, and at a
// header byte while the previous flush is still being read out.
// Reset clears parse state, the queue and the output register; the header
// store is not cleared. When the receiver stalls, hold the output word; the
// queue fills, then in_ready drops until words drain.
module soh_message_extractor (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     buffer_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_byte,
  output logic                     message_end,
  output logic                     run_last,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [soh_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import soh_pkg::*;

  logic     big_endian_words;
  logic     cfg_wr;
  logic     push_valid;
  q_entry_t push_data;
  q_entry_t q_head;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  logic     flush_done;
  hdr_t     held;

  // config register: write on the access phase, read back bit 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[CFG_AW-1] == CFG_REG_BEW) ? {31'd0, big_endian_words} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian_words <= 1'b0;
    end else if (cfg_wr && paddr[CFG_AW-1] == CFG_REG_BEW) begin
      big_endian_words <= pwdata[0];
    end
  end

  // parser: tracks offsets, fills the header store, queues words to send
  soh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bew        (big_endian_words),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .buffer_end (buffer_end),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full),
    .flush_done (flush_done),
    .held       (held)
  );

  soh_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // emitter: expands flush entries and drives the output register
  soh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .held        (held),
    .flush_done  (flush_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .message_end (message_end),
    .run_last    (run_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> !q_full)
    else $error("queue overflow");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> run_last)
    else $error("message end not on last word of run");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
